[rtl/sample_min_max_average_monitor_unit_assert.svh]
// assertion macros shared by the monitor checker
`ifndef SAMPLE_MIN_MAX_AVERAGE_MONITOR_UNIT_ASSERT_SVH
`define SAMPLE_MIN_MAX_AVERAGE_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SMMAM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("monitor check failed");

// next-cycle implication
`define SMMAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("monitor check failed");

`endif

[rtl/smmam_pkg.sv]
// types and constants of the sample min/max/average monitor
package smmam_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 32;
    localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_BITS   = $clog2(TOTAL_BITS);
    localparam int CMD_BITS    = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = SAMPLE_BITS;

    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_STOP   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT  = 1'd1;

    localparam logic [SAMPLE_BITS-1:0] HIGH_LIMIT_RST = 10'd921;
    localparam logic [SAMPLE_BITS-1:0] LOW_LIMIT_RST  = 10'd102;

    typedef struct packed {
        logic [CMD_BITS-1:0]    command;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] current;
        logic [SAMPLE_BITS-1:0] average;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic                   alarm;
        logic                   running;
        logic [COUNT_BITS-1:0]  sample_count;
    } t_out;

endpackage

[rtl/sample_min_max_average_monitor_unit.sv]
// sample min/max/average monitor: bit-serial accumulator and divider
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries a command and
// a converter sample: sample, start measuring, or stop and clear. Every
// command gives exactly one result on the output channel (o_out_valid /
// i_out_ready / o_out_data) with the statistics after the command.
// A sample taken while armed is added into the 42-bit total one bit per
// cycle through a serial full adder, the 32-bit count incrementing in the
// same pass; then the average is formed by a restoring divider that yields
// one quotient bit per cycle.
// Steps from the accepting edge to the result register being loaded:
//   accepted sample: serial add, divider preparation, divide, finish
//   any other command or ignored sample: preparation, divide, finish
// One item is in work at a time; o_in_ready is high only while idle, so
// a new item is taken only once the last one has reached the output register.
// The finished result sits in an output register, so the next item is
// taken while it still waits; a stalled receiver holds only the finish step.
// The user writes the limits over i_cfg_we / i_cfg_idx / i_cfg_wdata only while idle; the block does not enforce it.
// Reset (i_rst_n low, synchronous) disarms, clears the statistics, restores
// the default limits and empties the output register.
module sample_min_max_average_monitor_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  smmam_pkg::t_in                          i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output smmam_pkg::t_out                         o_out_data,
    input  logic                                    i_cfg_we,
    input  logic [smmam_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [smmam_pkg::CFG_DATA_BITS-1:0]     i_cfg_wdata
);

    localparam int SB = smmam_pkg::SAMPLE_BITS;
    localparam int CB = smmam_pkg::COUNT_BITS;
    localparam int TB = smmam_pkg::TOTAL_BITS;
    localparam int WB = smmam_pkg::STEP_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [WB-1:0] r_step;

    logic [SB-1:0] r_high_limit, r_low_limit;
    logic          r_armed;
    logic [TB-1:0] r_total;
    logic [CB-1:0] r_count;
    logic [SB-1:0] r_lowest, r_highest, r_last;
    logic          r_alarm;

    logic [SB-1:0] r_addend;
    logic          r_carry, r_ccarry;
    logic [CB-1:0] r_rem;
    logic [SB-1:0] r_quo;

    logic            r_out_valid;
    smmam_pkg::t_out r_out;

    logic          in_xfer, take_sample, out_free;
    logic          add_bit, add_cy;
    logic [CB:0]   div_shift;
    logic [CB-1:0] div_diff;
    logic          div_ge;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign take_sample = (i_in_data.command == smmam_pkg::CMD_SAMPLE) && r_armed
                         && !(&r_count);

    // serial full adder for the running total
    assign add_bit = r_total[0] ^ r_addend[0] ^ r_carry;
    assign add_cy  = (r_total[0] & r_addend[0]) | (r_carry & (r_total[0] ^ r_addend[0]));

    // one restoring division step, the remainder always fits below the count
    assign div_shift = {r_rem, r_quo[SB-1]};
    assign div_ge    = div_shift >= {1'b0, r_count};
    assign div_diff  = div_shift[CB-1:0] - r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = take_sample ? S_ADD : S_PREP;
                end
            end
            S_ADD: begin
                if (r_step == WB'(TB - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_step == WB'(SB - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_high_limit <= smmam_pkg::HIGH_LIMIT_RST;
            r_low_limit  <= smmam_pkg::LOW_LIMIT_RST;
            r_armed      <= 1'b0;
            r_total      <= '0;
            r_count      <= '0;
            r_lowest     <= '1;
            r_highest    <= '0;
            r_last       <= '0;
            r_alarm      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    smmam_pkg::REG_HIGH_LIMIT: r_high_limit <= i_cfg_wdata;
                    smmam_pkg::REG_LOW_LIMIT:  r_low_limit  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_alarm  <= take_sample
                                    && ((i_in_data.sample > r_high_limit)
                                    || (i_in_data.sample < r_low_limit));
                        r_step   <= '0;
                        r_carry  <= 1'b0;
                        r_ccarry <= 1'b1;
                        r_addend <= i_in_data.sample;
                        case (i_in_data.command)
                            smmam_pkg::CMD_SAMPLE: begin
                                if (take_sample) begin
                                    r_last <= i_in_data.sample;
                                    if (i_in_data.sample > r_highest) begin
                                        r_highest <= i_in_data.sample;
                                    end
                                    if (i_in_data.sample < r_lowest) begin
                                        r_lowest <= i_in_data.sample;
                                    end
                                end
                            end
                            smmam_pkg::CMD_START: r_armed <= 1'b1;
                            smmam_pkg::CMD_STOP: begin
                                r_armed   <= 1'b0;
                                r_total   <= '0;
                                r_count   <= '0;
                                r_lowest  <= '1;
                                r_highest <= '0;
                                r_last    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD: begin
                    r_total  <= {add_bit, r_total[TB-1:1]};
                    r_addend <= {1'b0, r_addend[SB-1:1]};
                    r_carry  <= add_cy;
                    // count rides along through its own half adder, carry in of one
                    if (r_step < WB'(CB)) begin
                        r_count  <= {r_count[0] ^ r_ccarry, r_count[CB-1:1]};
                        r_ccarry <= r_count[0] & r_ccarry;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_PREP: begin
                    // high part of the total is below any nonzero count, so ten steps suffice
                    r_rem  <= r_total[TB-1:SB];
                    r_quo  <= r_total[SB-1:0];
                    r_step <= '0;
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_diff : div_shift[CB-1:0];
                    r_quo  <= {r_quo[SB-2:0], div_ge};
                    r_step <= r_step + 1'b1;
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // result payload, loaded once the divider has finished
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.current      <= r_last;
            r_out.average      <= (r_count == '0) ? '0 : r_quo;
            r_out.minimum      <= r_lowest;
            r_out.maximum      <= r_highest;
            r_out.alarm        <= r_alarm;
            r_out.running      <= r_armed;
            r_out.sample_count <= r_count;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/smmam_checker.sv]
// port-level checks for the sample min/max/average monitor
`include "sample_min_max_average_monitor_unit_assert.svh"

module smmam_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input smmam_pkg::t_out                     o_out_data
);

    logic out_stall;
    assign out_stall = o_out_valid && !i_out_ready;

    // a stalled result stays put
    `SMMAM_ASSERT_NEXT(a_out_hold_valid, out_stall, o_out_valid)
    `SMMAM_ASSERT_NEXT(a_out_hold_data, out_stall, $stable(o_out_data))

    // one item in work at a time
    `SMMAM_ASSERT_NEXT(a_busy_after_xfer, i_in_valid && o_in_ready, !o_in_ready)

    // average lies between minimum and maximum once samples exist
    `SMMAM_ASSERT_NOW(a_avg_range, o_out_valid && (o_out_data.sample_count != '0), (o_out_data.average <= o_out_data.maximum) && (o_out_data.minimum <= o_out_data.average))

    // alarm only comes from a sample taken while armed
    `SMMAM_ASSERT_NOW(a_alarm_armed, o_out_valid && o_out_data.alarm, o_out_data.running)

endmodule

bind sample_min_max_average_monitor_unit smmam_checker u_smmam_checker (.*);
